### rtl/core/fefa_pkg.sv
package fefa_pkg;

    // Limit on pairs per distribution before the result is forced to all ones
    localparam int unsigned MAX_STATES = 256;

    localparam int unsigned OPA_W  = 16;
    localparam int unsigned OPB_W  = 21;
    localparam int unsigned PROD_W = OPA_W + OPB_W;
    localparam int unsigned LOG_W  = 19;
    localparam int unsigned SUM_W  = 50;
    localparam int unsigned CNT_W  = 13;
    localparam int unsigned OUT_W  = 32;

    localparam logic [15:0]       Q_ONE       = 16'd32768;
    localparam logic [LOG_W:0]    LOG2_MAX    = 20'(15 * 32768);
    localparam logic [OPB_W-1:0]  KL_PENALTY  = 21'(1 << 20);
    localparam logic [CNT_W-1:0]  COUNT_MAX   = 13'h1FFF;
    localparam logic [CNT_W-1:0]  STATE_LIMIT = CNT_W'(MAX_STATES);
    localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
    localparam logic [OUT_W-1:0]  OUT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOGQ,
        S_LOGP,
        S_DIFF,
        S_KL,
        S_ENT,
        S_ACC,
        S_EMIT
    } t_state;

    // Pieces of one log2 evaluation: integer part plus segment base, and the
    // interpolation operands for the shared multiplier
    typedef struct packed {
        logic [LOG_W-1:0] base;
        logic [13:0]      span;
        logic [12:0]      rem;
    } t_log_parts;

    // Breakpoints of the four-segment correction curve, Q15
    function automatic logic [14:0] seg_point(input logic [2:0] idx);
        logic [14:0] v;
        case (idx)
            3'd0:    v = 15'd0;
            3'd1:    v = 15'd10549;
            3'd2:    v = 15'd19167;
            3'd3:    v = 15'd26462;
            default: v = 15'd0;
        endcase
        // The top breakpoint 32768 does not fit 15 bits; it is handled as span
        return v;
    endfunction

endpackage

### rtl/core/fefa_if.sv
interface fefa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] q_prob;
    logic [15:0] p_prob;
    logic        last_state;

    modport source (output valid, output q_prob, output p_prob, output last_state,
                    input ready);
    modport sink   (input valid, input q_prob, input p_prob, input last_state,
                    output ready);
endinterface

interface fefa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] free_energy;
    logic        too_many_states;

    modport source (output valid, output free_energy, output too_many_states,
                    input ready);
    modport sink   (input valid, input free_energy, input too_many_states,
                    output ready);
endinterface

### rtl/core/fixed_point_free_energy_accumulator_unit.sv
// Streaming free-energy accumulator: each (q, p) word adds the KL term
// q*(max(log2 q - log2 p, 0) + penalty when p is zero) and the entropy term
// q*(15 - log2 q) into a 50-bit Q20.30 sum, with log2 by Mitchell's method and
// a four-segment correction. Ready stays low from one acceptance until the
// pair is summed, so no new pair is taken meanwhile: one shared 16x21
// multiplier is used four times in sequence (two log interpolations, then the
// two weighting products), each followed by a register. A pair marked last
// then passes through a state that loads the result register, waiting there
// while that register still holds an untaken word. The result is the sum
// shifted right by 15, saturated to 32 bits, or all ones with too_many_states
// set when more than MAX_STATES pairs came in; the sum and count then clear.
module fixed_point_free_energy_accumulator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fefa_in_if.sink     i_in,
    fefa_out_if.source  o_out
);
    import fefa_pkg::*;

    t_state            r_state;
    t_state            n_state;

    logic [15:0]       r_q;
    logic [15:0]       r_p;
    logic              r_last;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [LOG_W-1:0]  r_lbase;
    logic [LOG_W-1:0]  r_lq;
    logic [LOG_W-1:0]  r_lp;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_fe;
    logic              r_out_tms;

    logic              accept;
    logic              out_free;
    logic [15:0]       log_in;
    t_log_parts        log_parts;
    logic [OPA_W-1:0]  mul_a;
    logic [OPB_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [LOG_W-1:0]  interp;
    logic [LOG_W-1:0]  diff;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-16:0] sum_shr;
    logic              do_acc;
    logic              do_emit;

    fefa_log2 u_log2 (
        .i_n     (log_in),
        .o_parts (log_parts)
    );

    fefa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign interp   = LOG_W'(prod >> 13);
    assign diff     = (r_lq > r_lp) ? (r_lq - r_lp) : '0;
    assign sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(prod);
    assign sum_shr  = r_sum[SUM_W-1:15];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOGQ;
                end
            end
            S_LOGQ: n_state = S_LOGP;
            S_LOGP: n_state = S_DIFF;
            S_DIFF: n_state = S_KL;
            S_KL:   n_state = S_ENT;
            S_ENT:  n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and shared-unit operand selection
    always_comb begin
        i_in.ready = 1'b0;
        log_in     = r_q;
        mul_a      = '0;
        mul_b      = '0;
        do_acc     = 1'b0;
        do_emit    = 1'b0;
        case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_LOGQ: begin
                log_in = r_q;
                mul_a  = OPA_W'(log_parts.span);
                mul_b  = OPB_W'(log_parts.rem);
            end
            S_LOGP: begin
                log_in = r_p;
                mul_a  = OPA_W'(log_parts.span);
                mul_b  = OPB_W'(log_parts.rem);
            end
            S_KL: begin
                mul_a = r_q;
                mul_b = OPB_W'(diff) + ((r_p == 16'd0) ? KL_PENALTY : '0);
            end
            S_ENT: begin
                mul_a  = r_q;
                mul_b  = OPB_W'(LOG2_MAX - (LOG_W + 1)'(r_lq));
                do_acc = 1'b1;
            end
            S_ACC:  do_acc = 1'b1;
            S_EMIT: do_emit = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pair capture, log results and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            if (accept) begin
                r_q    <= (i_in.q_prob > Q_ONE) ? Q_ONE : i_in.q_prob;
                r_p    <= (i_in.p_prob > Q_ONE) ? Q_ONE : i_in.p_prob;
                r_last <= i_in.last_state;
                if (r_count < COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (r_state == S_LOGQ) begin
                r_lbase <= log_parts.base;
            end
            if (r_state == S_LOGP) begin
                r_lq    <= r_lbase + interp;
                r_lbase <= log_parts.base;
            end
            if (r_state == S_DIFF) begin
                r_lp <= r_lbase + interp;
            end
            if (do_acc) begin
                r_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            end
            if (do_emit) begin
                r_sum   <= '0;
                r_count <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (do_emit) begin
                r_out_valid <= 1'b1;
                if (r_count > STATE_LIMIT) begin
                    r_out_fe  <= OUT_MAX;
                    r_out_tms <= 1'b1;
                end else begin
                    r_out_fe  <= (|sum_shr[SUM_W-16:OUT_W]) ? OUT_MAX : sum_shr[OUT_W-1:0];
                    r_out_tms <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.free_energy     = r_out_fe;
    assign o_out.too_many_states = r_out_tms;

endmodule

### rtl/core/fefa_log2.sv
module fefa_log2 (
    input  logic [15:0]         i_n,
    output fefa_pkg::t_log_parts o_parts
);
    import fefa_pkg::*;

    logic [3:0]  top;
    logic [15:0] resid;
    logic [15:0] shifted;
    logic [14:0] frac;
    logic [1:0]  seg;
    logic [15:0] pt_a;
    logic [15:0] pt_b;

    // Highest set bit; 0 and 1 both give top = 0 and a zero fraction
    always_comb begin
        top = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (i_n[i]) begin
                top = 4'(i);
            end
        end
    end

    always_comb begin
        resid   = i_n & ~(16'd1 << top);
        shifted = resid << (4'd15 - top);
        frac    = shifted[14:0];
        seg     = frac[14:13];
        pt_a    = {1'b0, seg_point({1'b0, seg})};
        // upper breakpoint of the last segment is 1.0 in Q15
        if (seg == 2'd3) begin
            pt_b = Q_ONE;
        end else begin
            pt_b = {1'b0, seg_point({1'b0, seg} + 3'd1)};
        end
        o_parts.base = {top, 15'd0} + LOG_W'(pt_a);
        o_parts.span = 14'(pt_b - pt_a);
        o_parts.rem  = frac[12:0];
    end

endmodule

### rtl/core/fefa_mul.sv
module fefa_mul (
    input  logic                           i_clk,
    input  logic [fefa_pkg::OPA_W-1:0]     i_a,
    input  logic [fefa_pkg::OPB_W-1:0]     i_b,
    output logic [fefa_pkg::PROD_W-1:0]    o_prod
);
    import fefa_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
